/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the module's clock and reset
`define ASSERT_DEF(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

/* hw/rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// types and constants of the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int FUNC_W     = 3;
   localparam int NUM_W      = 16;
   localparam int DEN_W      = 16;
   localparam int OP_W       = 16;
   localparam int SHIFT_W    = $clog2(OP_W);
   localparam int MUL_W      = 17;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int RES_NUM_W  = 34;
   localparam int RES_DEN_W  = 32;

   localparam int REQ_DATA_W = 64;
   localparam int FN_LSB     = 0;
   localparam int FD_LSB     = 16;
   localparam int SN_LSB     = 32;
   localparam int SD_LSB     = 48;

   localparam int RES_W      = RES_NUM_W + RES_DEN_W;
   localparam int LESS_BIT   = RES_W;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - RES_W - 1;

   localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LT  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_RED = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_DIVA_GO,
      ST_DIVA_WAIT,
      ST_DIVB_GO,
      ST_DIVB_WAIT,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_FINISH
   } state_type;

endpackage

/* hw/rtl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// add, subtract, multiply, divide, compare and reduce of two fractions.
// One word is taken at a time, and the request side is not ready again
// until the sequencer is back in idle. Multiply, divide and less-than make
// three passes through a shared 17x17 multiplier. Add and subtract work
// over the lcm of the denominators. They run a binary gcd, then two serial
// divisions by the gcd, then the three multiplier passes. Reduce runs a
// gcd and the two divisions but skips the multiplier. An erroneous word
// goes straight to the finish state. The sequencer returns to idle as the
// result is loaded into the output register. A finished result waits
// while the output register still holds a word that has not been
// accepted. The next word is accepted as soon as the sequencer is back in
// idle, even while the last result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_arithmetic_unit #(
   parameter int DEN_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // first_num, first_den, second_num, second_den
   input  logic [rau_pkg::REQ_DATA_W-1:0] req_tdata,
   // func
   input  logic [rau_pkg::FUNC_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // res_num, res_den, less, zero fill
   output logic [rau_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // error
   output logic                           rsp_tuser
);
   import rau_pkg::*;

   localparam int DW = (DEN_WIDTH < DEN_W) ? DEN_WIDTH : DEN_W;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]           func_ff, func_in;
   logic signed [NUM_W-1:0]     n1_ff, n1_in, n2_ff, n2_in;
   logic [DW-1:0]               d1_ff, d1_in, d2_ff, d2_in;
   logic                        err_ff, err_in;
   logic [OP_W-1:0]             qa_ff, qa_in, qb_ff, qb_in;
   logic signed [PROD_W-1:0]    pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RES_NUM_W-1:0]        res_num_ff, res_num_in;
   logic [RES_DEN_W-1:0]        res_den_ff, res_den_in;
   logic                        less_ff, less_in, error_ff, error_in;

   logic [DW-1:0]               req_d1, req_d2;
   logic [FUNC_W-1:0]           req_func;
   logic                        req_err, accept, out_load, addsub;
   logic [OP_W-1:0]             d1_ext, d2_ext, abs_n1, abs_n2;

   logic                        gcd_start, gcd_done, div_start, div_done;
   logic [OP_W-1:0]             gcd_value, div_dividend, div_quotient;

   logic signed [MUL_W-1:0]     mul_x, mul_y;
   logic signed [PROD_W-1:0]    prod;

   logic signed [RES_NUM_W-1:0] red_num, fin_num;
   logic [RES_DEN_W-1:0]        fin_den;
   logic                        fin_less;

   logic                        rsp_err_word, rsp_less_word, rsp_frac_zero;

   // input unpacking and checks
   assign req_func = req_tuser;
   assign req_d1   = req_tdata[FD_LSB +: DW];
   assign req_d2   = req_tdata[SD_LSB +: DW];
   assign req_err  = (req_func > FUNC_RED) || (req_d1 == '0) ||
                     (req_func != FUNC_RED && req_d2 == '0) ||
                     (req_func == FUNC_DIV && req_tdata[SN_LSB +: NUM_W] == '0);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   assign addsub = (func_ff == FUNC_ADD) || (func_ff == FUNC_SUB);
   assign d1_ext = OP_W'(d1_ff);
   assign d2_ext = OP_W'(d2_ff);
   assign abs_n1 = n1_ff[NUM_W-1] ? (~n1_ff + 1'b1) : n1_ff;
   assign abs_n2 = n2_ff[NUM_W-1] ? (~n2_ff + 1'b1) : n2_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      gcd_start = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_err) begin
                  state_in = ST_FINISH;
               end else if (req_func == FUNC_ADD || req_func == FUNC_SUB ||
                            req_func == FUNC_RED) begin
                  state_in = ST_GCD_GO;
               end else begin
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_GCD_GO: begin
            gcd_start = 1'b1;
            state_in  = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (gcd_done) begin
               state_in = ST_DIVA_GO;
            end
         end
         ST_DIVA_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVA_WAIT;
         end
         ST_DIVA_WAIT: begin
            if (div_done) begin
               state_in = ST_DIVB_GO;
            end
         end
         ST_DIVB_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIVB_WAIT;
         end
         ST_DIVB_WAIT: begin
            if (div_done) begin
               state_in = (func_ff == FUNC_RED) ? ST_FINISH : ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // shared divider operand
   assign div_dividend = (state_ff == ST_DIVA_GO) ? (addsub ? d2_ext : abs_n1) : d1_ext;

   // shared multiplier operands
   always_comb begin
      mul_x = $signed({n1_ff[NUM_W-1], n1_ff});
      mul_y = $signed({1'b0, d2_ext});
      case (state_ff)
         ST_MUL_A: begin
            mul_x = $signed({n1_ff[NUM_W-1], n1_ff});
            if (addsub) begin
               mul_y = $signed({1'b0, qa_ff});
            end else if (func_ff == FUNC_MUL) begin
               mul_y = $signed({n2_ff[NUM_W-1], n2_ff});
            end else begin
               mul_y = $signed({1'b0, d2_ext});
            end
         end
         ST_MUL_B: begin
            mul_x = $signed({n2_ff[NUM_W-1], n2_ff});
            mul_y = addsub ? $signed({1'b0, qb_ff}) : $signed({1'b0, d1_ext});
         end
         ST_MUL_C: begin
            mul_x = addsub ? $signed({1'b0, qb_ff}) : $signed({1'b0, d1_ext});
            mul_y = (func_ff == FUNC_DIV) ? $signed({1'b0, abs_n2}) :
                                            $signed({1'b0, d2_ext});
         end
         default: begin
            mul_x = $signed({n1_ff[NUM_W-1], n1_ff});
            mul_y = $signed({1'b0, d2_ext});
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   // result assembly
   assign red_num = $signed({{(RES_NUM_W-OP_W){1'b0}}, qa_ff});

   always_comb begin
      fin_num  = '0;
      fin_den  = '0;
      fin_less = 1'b0;
      case (func_ff)
         FUNC_ADD: begin
            fin_num = pa_ff + pb_ff;
            fin_den = pc_ff[RES_DEN_W-1:0];
         end
         FUNC_SUB: begin
            fin_num = pa_ff - pb_ff;
            fin_den = pc_ff[RES_DEN_W-1:0];
         end
         FUNC_MUL: begin
            fin_num = pa_ff;
            fin_den = pc_ff[RES_DEN_W-1:0];
         end
         FUNC_DIV: begin
            fin_num = n2_ff[NUM_W-1] ? -pa_ff : pa_ff;
            fin_den = pc_ff[RES_DEN_W-1:0];
         end
         FUNC_LT: begin
            fin_less = (pa_ff < pb_ff);
         end
         FUNC_RED: begin
            fin_num = n1_ff[NUM_W-1] ? -red_num : red_num;
            fin_den = {{(RES_DEN_W-OP_W){1'b0}}, qb_ff};
         end
         default: begin
            fin_num  = '0;
            fin_den  = '0;
            fin_less = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      func_in      = func_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      err_in       = err_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      less_in      = less_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         func_in = req_func;
         n1_in   = $signed(req_tdata[FN_LSB +: NUM_W]);
         n2_in   = $signed(req_tdata[SN_LSB +: NUM_W]);
         d1_in   = req_d1;
         d2_in   = req_d2;
         err_in  = req_err;
      end
      if (state_ff == ST_DIVA_WAIT && div_done) begin
         qa_in = div_quotient;
      end
      if (state_ff == ST_DIVB_WAIT && div_done) begin
         qb_in = div_quotient;
      end
      if (state_ff == ST_MUL_A) begin
         pa_in = prod;
      end
      if (state_ff == ST_MUL_B) begin
         pb_in = prod;
      end
      if (state_ff == ST_MUL_C) begin
         pc_in = prod;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         error_in     = err_ff;
         res_num_in   = err_ff ? '0 : fin_num;
         res_den_in   = err_ff ? '0 : fin_den;
         less_in      = err_ff ? 1'b0 : fin_less;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff    <= func_in;
      n1_ff      <= n1_in;
      n2_ff      <= n2_in;
      d1_ff      <= d1_in;
      d2_ff      <= d2_in;
      err_ff     <= err_in;
      qa_ff      <= qa_in;
      qb_ff      <= qb_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      pc_ff      <= pc_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      less_ff    <= less_in;
      error_ff   <= error_in;
   end

   rau_gcd u_gcd (
      .clock     (clock),
      .reset     (reset),
      .start     (gcd_start),
      .op_a      (addsub ? d1_ext : abs_n1),
      .op_b      (addsub ? d2_ext : d1_ext),
      .done      (gcd_done),
      .gcd_value (gcd_value)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gcd_value),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, less_ff, res_den_ff, res_num_ff};
   assign rsp_tuser  = error_ff;

   assign rsp_err_word  = rsp_tvalid && rsp_tuser;
   assign rsp_less_word = rsp_tvalid && rsp_tdata[LESS_BIT];
   assign rsp_frac_zero = (rsp_tdata[RES_W-1:0] == '0);

   `ASSERT_DEF(a_err_word_zero, rsp_err_word |-> rsp_frac_zero, "error word carries data")
   `ASSERT_DEF(a_less_word_zero, rsp_less_word |-> rsp_frac_zero, "less word carries a fraction")
   `ASSERT_DEF(a_gcd_nonzero, gcd_done |-> (gcd_value != '0), "gcd of nonzero operands is zero")
   `ASSERT_DEF(a_div_by_nonzero, div_start |-> (gcd_value != '0), "zero divisor at divider start")

endmodule

/* hw/rtl/rau_gcd.sv */
// ----------------------------------------------------------------------------
// rau_gcd
// binary gcd engine, one shift or subtract-and-shift per cycle
// ----------------------------------------------------------------------------
module rau_gcd (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [rau_pkg::OP_W-1:0] op_a,
   input  logic [rau_pkg::OP_W-1:0] op_b,
   output logic                     done,
   output logic [rau_pkg::OP_W-1:0] gcd_value
);
   import rau_pkg::*;

   logic [OP_W-1:0]    a_ff, a_in, b_ff, b_in, g_ff, g_in;
   logic [SHIFT_W-1:0] k_ff, k_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [OP_W:0]      diff;
   logic               a_lt_b;
   logic [OP_W-1:0]    mag;

   assign diff   = {1'b0, a_ff} - {1'b0, b_ff};
   assign a_lt_b = diff[OP_W];
   assign mag    = a_lt_b ? (~diff[OP_W-1:0] + 1'b1) : diff[OP_W-1:0];

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff == '0 || b_ff == '0) begin
            g_in    = (a_ff | b_ff) << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_lt_b) begin
            b_in = mag >> 1;
         end else begin
            a_in = mag >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done      = done_ff;
   assign gcd_value = g_ff;

endmodule

/* hw/rtl/rau_div.sv */
// ----------------------------------------------------------------------------
// rau_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rau_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [rau_pkg::OP_W-1:0] dividend,
   input  logic [rau_pkg::OP_W-1:0] divisor,
   output logic                     done,
   output logic [rau_pkg::OP_W-1:0] quotient
);
   import rau_pkg::*;

   logic [OP_W-1:0]    rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [SHIFT_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [OP_W:0]      shifted, diff;
   logic               ge;

   assign shifted = {rem_ff, quo_ff[OP_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = !diff[OP_W];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[OP_W-1:0] : shifted[OP_W-1:0];
         quo_in = {quo_ff[OP_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SHIFT_W'(OP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
